// ===== sv/rsms_pkg.sv =====
// Package: shared types and constants of the rotor spin-up mode sequencer.
package rsms_pkg;

	localparam int LEVEL_W = 16;
	localparam int CMD_W   = 4;

	localparam logic [CMD_W-1:0] CMD_START    = 4'd1;
	localparam logic [CMD_W-1:0] CMD_HOVER    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_LOCALIZE = 4'd3;
	localparam logic [CMD_W-1:0] CMD_LAND     = 4'd9;

	localparam logic REG_UPPER = 1'b0;
	localparam logic REG_LOWER = 1'b1;

	typedef enum logic [1:0] {
		STAGE_SPINUP   = 2'd0,
		STAGE_IDLE     = 2'd1,
		STAGE_HOVER    = 2'd2,
		STAGE_LOCALIZE = 2'd3
	} stage_t;

	// what a result does to one motor setpoint
	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_ZERO  = 2'd1,
		OP_LEVEL = 2'd2,
		OP_SCALE = 2'd3
	} op_t;

	typedef struct packed {
		op_t    upper_op;
		op_t    lower_op;
		logic   sel_lower;
		logic   ready;
		logic   run;
		stage_t stage;
		logic   rejected;
	} step_t;

endpackage

// ===== sv/rotor_spinup_mode_sequencer.sv =====
// Top level of the rotor spin-up mode sequencer.
//
// channel  | handshake                  | payload
// item     | item_valid / item_stall    | mode, command_code
// result   | result_valid / result_stall| upper/lower_motor_level, rotors_ready,
//          |                            | run_controller, flight_stage, command_rejected
// config   | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// One item per cycle while item_stall is low; each result passes the decode, product,
// reciprocal multiply and output register stages before result_valid rises.
// Mode state updates at decode; setpoints are held in the output register.
// Each stage moves when the one after it is empty or moving, so items keep
// flowing into free stages while a result waits on result_stall.
// Reset: landed, ramp off, stage spinning up, both setpoints zero.
module rotor_spinup_mode_sequencer #(
	parameter int RAMP_STEPS = 150
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         mode,
	input  logic [rsms_pkg::CMD_W-1:0]   command_code,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [rsms_pkg::LEVEL_W-1:0] upper_motor_level,
	output logic [rsms_pkg::LEVEL_W-1:0] lower_motor_level,
	output logic                         rotors_ready,
	output logic                         run_controller,
	output logic [1:0]                   flight_stage,
	output logic                         command_rejected,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import rsms_pkg::*;

	localparam int NW = $clog2(RAMP_STEPS + 1);

	logic               v1_q, v2_q, v3_q, vo_q;
	logic               en1, en2, en3, en_o;
	logic               accept;
	step_t              step_s1, step_s2, step_s3;
	logic [NW-1:0]      num_s1;
	logic [LEVEL_W-1:0] upper_level;
	logic [LEVEL_W-1:0] lower_level;
	logic [LEVEL_W-1:0] level_s1;
	logic [LEVEL_W-1:0] quot_s3;

	assign en_o       = !vo_q || !result_stall;
	assign en3        = !v3_q || en_o;
	assign en2        = !v2_q || en3;
	assign en1        = !v1_q || en2;
	assign item_stall = !en1;
	assign accept     = item_valid && en1;

	rsms_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.upper_level (upper_level),
		.lower_level (lower_level)
	);

	rsms_ctrl #(
		.RAMP_STEPS (RAMP_STEPS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.mode         (mode),
		.command_code (command_code),
		.step_s1      (step_s1),
		.num_s1       (num_s1)
	);

	assign level_s1 = step_s1.sel_lower ? lower_level : upper_level;

	rsms_scale #(
		.RAMP_STEPS (RAMP_STEPS)
	) u_scale (
		.clk      (clk),
		.en2      (en2),
		.en3      (en3),
		.num_s1   (num_s1),
		.level_s1 (level_s1),
		.quot_s3  (quot_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= accept;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
			if (en_o) begin
				vo_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			step_s2 <= step_s1;
		end
		if (en3) begin
			step_s3 <= step_s2;
		end
	end

	// setpoints are state: they hold across results and clear on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_motor_level <= '0;
			lower_motor_level <= '0;
			rotors_ready      <= 1'b0;
			run_controller    <= 1'b0;
			flight_stage      <= STAGE_SPINUP;
			command_rejected  <= 1'b0;
		end else if (en_o && v3_q) begin
			case (step_s3.upper_op)
				OP_HOLD:  upper_motor_level <= upper_motor_level;
				OP_ZERO:  upper_motor_level <= '0;
				OP_LEVEL: upper_motor_level <= upper_level;
				OP_SCALE: upper_motor_level <= quot_s3;
				default:  upper_motor_level <= upper_motor_level;
			endcase
			case (step_s3.lower_op)
				OP_HOLD:  lower_motor_level <= lower_motor_level;
				OP_ZERO:  lower_motor_level <= '0;
				OP_LEVEL: lower_motor_level <= lower_level;
				OP_SCALE: lower_motor_level <= quot_s3;
				default:  lower_motor_level <= lower_motor_level;
			endcase
			rotors_ready     <= step_s3.ready;
			run_controller   <= step_s3.run;
			flight_stage     <= step_s3.stage;
			command_rejected <= step_s3.rejected;
		end
	end

	assign result_valid = vo_q;

endmodule

// ===== sv/rsms_cfg.sv =====
// APB register file holding the two idle levels.
module rsms_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output logic [rsms_pkg::LEVEL_W-1:0] upper_level,
	output logic [rsms_pkg::LEVEL_W-1:0] lower_level
);
	import rsms_pkg::*;

	logic                wr;
	logic [LEVEL_W-1:0]  upper_q;
	logic [LEVEL_W-1:0]  lower_q;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= '0;
			lower_q <= '0;
		end else if (wr) begin
			if (paddr[2] == REG_LOWER) begin
				lower_q <= pwdata[LEVEL_W-1:0];
			end else begin
				upper_q <= pwdata[LEVEL_W-1:0];
			end
		end
	end

	assign prdata      = (paddr[2] == REG_LOWER) ? 32'(lower_q) : 32'(upper_q);
	assign upper_level = upper_q;
	assign lower_level = lower_q;

endmodule

// ===== sv/rsms_ctrl.sv =====
// Mode and ramp state: decodes each item and registers its step control.
module rsms_ctrl #(
	parameter int RAMP_STEPS = 150,
	localparam int NW = $clog2(RAMP_STEPS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       mode,
	input  logic [rsms_pkg::CMD_W-1:0] command_code,
	output rsms_pkg::step_t            step_s1,
	output logic [NW-1:0]              num_s1
);
	import rsms_pkg::*;

	localparam int CW = $clog2(2 * RAMP_STEPS + 2);
	localparam logic [CW-1:0] STEPS     = CW'(RAMP_STEPS);
	localparam logic [CW-1:0] STEPS_TWO = CW'(2 * RAMP_STEPS);

	stage_t         stage_q, stage_d;
	logic           landed_q, landed_d;
	logic           ramp_en_q, ramp_en_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [CW-1:0]  cnt_inc;
	logic [CW-1:0]  cnt_lo;
	logic           ph_up;
	logic           ph_lo;
	step_t          step;
	logic [NW-1:0]  num;

	assign cnt_inc = (cnt_q <= STEPS_TWO) ? cnt_q + CW'(1) : cnt_q;
	assign cnt_lo  = cnt_inc - STEPS;
	assign ph_up   = cnt_inc < STEPS;
	assign ph_lo   = !ph_up && (cnt_inc < STEPS_TWO);

	// next state
	always_comb begin
		stage_d   = stage_q;
		landed_d  = landed_q;
		ramp_en_d = ramp_en_q;
		cnt_d     = cnt_q;
		if (accept) begin
			if (!mode) begin
				if (ramp_en_q) begin
					cnt_d = cnt_inc;
					if (!ph_up && !ph_lo && stage_q == STAGE_SPINUP) begin
						stage_d = STAGE_IDLE;
					end
				end
			end else begin
				case (command_code)
					CMD_START: begin
						if (landed_q) begin
							cnt_d     = '0;
							ramp_en_d = 1'b1;
							landed_d  = 1'b0;
							stage_d   = STAGE_SPINUP;
						end
					end
					CMD_HOVER: begin
						if (stage_q == STAGE_IDLE || stage_q == STAGE_LOCALIZE) begin
							stage_d = STAGE_HOVER;
						end
					end
					CMD_LOCALIZE: begin
						if (stage_q == STAGE_HOVER) begin
							stage_d = STAGE_LOCALIZE;
						end
					end
					CMD_LAND: begin
						ramp_en_d = 1'b0;
						cnt_d     = '0;
						landed_d  = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// step outputs
	always_comb begin
		step.upper_op  = OP_HOLD;
		step.lower_op  = OP_HOLD;
		step.sel_lower = 1'b0;
		step.ready     = 1'b0;
		step.rejected  = 1'b0;
		step.stage     = stage_d;
		num            = '0;
		if (!mode) begin
			if (ramp_en_q) begin
				if (ph_up) begin
					step.upper_op = OP_SCALE;
					step.lower_op = OP_ZERO;
					num           = cnt_inc[NW-1:0];
				end else if (ph_lo) begin
					step.upper_op  = OP_LEVEL;
					step.lower_op  = OP_SCALE;
					step.sel_lower = 1'b1;
					num            = cnt_lo[NW-1:0];
				end else begin
					step.ready = 1'b1;
				end
			end
		end else begin
			case (command_code)
				CMD_START: begin
					if (landed_q) begin
						step.upper_op = OP_ZERO;
						step.lower_op = OP_ZERO;
					end else begin
						step.rejected = 1'b1;
					end
				end
				CMD_HOVER: begin
					step.rejected = !(stage_q == STAGE_IDLE || stage_q == STAGE_LOCALIZE);
				end
				CMD_LOCALIZE: begin
					step.rejected = (stage_q != STAGE_HOVER);
				end
				CMD_LAND: begin
					step.upper_op = OP_ZERO;
					step.lower_op = OP_ZERO;
				end
				default: begin
					step.rejected = 1'b1;
				end
			endcase
		end
		step.run = step.ready && (stage_d == STAGE_HOVER || stage_d == STAGE_LOCALIZE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= STAGE_SPINUP;
			landed_q  <= 1'b1;
			ramp_en_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			stage_q   <= stage_d;
			landed_q  <= landed_d;
			ramp_en_q <= ramp_en_d;
			cnt_q     <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
			num_s1  <= num;
		end
	end

endmodule

// ===== sv/rsms_scale.sv =====
// Ramp scaling: num * level / RAMP_STEPS as a product stage and a reciprocal stage.
module rsms_scale #(
	parameter int RAMP_STEPS = 150,
	localparam int NW = $clog2(RAMP_STEPS + 1)
) (
	input  logic                         clk,
	input  logic                         en2,
	input  logic                         en3,
	input  logic [NW-1:0]                num_s1,
	input  logic [rsms_pkg::LEVEL_W-1:0] level_s1,
	output logic [rsms_pkg::LEVEL_W-1:0] quot_s3
);
	import rsms_pkg::*;

	localparam int PW = LEVEL_W + NW;
	localparam int SH = PW + $clog2(RAMP_STEPS);
	localparam int MW = PW + 1;
	localparam int FW = PW + MW;
	// exact floor division for any PW-bit numerator
	localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(RAMP_STEPS) - 64'd1)
		/ 64'(RAMP_STEPS);

	logic [PW-1:0] prod_s2;
	logic [FW-1:0] full;

	assign full = FW'(prod_s2) * FW'(RECIP[MW-1:0]);

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2 <= PW'(num_s1) * PW'(level_s1);
		end
		if (en3) begin
			quot_s3 <= full[SH +: LEVEL_W];
		end
	end

endmodule
